[design/shpo_pkg.sv]
// Package: shared types, constants and the arctangent table for the heading pipeline.
`default_nettype none
package shpo_pkg;
  localparam int CoordW = 24;
  localparam int DiffW = 25;
  localparam int VecW = 57;   // 25-bit diff scaled by 2^30, plus growth
  localparam int OffW = 20;
  localparam int RotW = 56;   // offset * 1/K in Q32, plus growth
  localparam int AngW = 30;   // microdegree accumulator
  localparam int HeadW = 19;
  localparam logic [31:0] InvKQ32 = 32'd2608131497;
  localparam logic signed [AngW-1:0] HalfTurnUdeg = 30'sd180000000;
  // floor(n / 1000) = (n * Recip1000) >> RecipShift for n below 2^32
  localparam logic [28:0] Recip1000 = 29'd274877907;
  localparam int RecipShift = 38;
  // |z| + 500 at or above this gives a heading past 180000
  localparam logic [AngW-1:0] HeadSatUdeg = 30'd180001000;

  function automatic logic signed [AngW-1:0] atan_udeg(input int i);
    logic signed [AngW-1:0] r;
    case (i)
      0: r = 30'sd45000000;  1: r = 30'sd26565051; 2: r = 30'sd14036243;
      3: r = 30'sd7125016;   4: r = 30'sd3576334;  5: r = 30'sd1789911;
      6: r = 30'sd895174;    7: r = 30'sd447614;   8: r = 30'sd223811;
      9: r = 30'sd111906;    10: r = 30'sd55953;   11: r = 30'sd27976;
      12: r = 30'sd13988;    13: r = 30'sd6994;    14: r = 30'sd3497;
      15: r = 30'sd1749;     16: r = 30'sd874;     17: r = 30'sd437;
      18: r = 30'sd219;      19: r = 30'sd109;     20: r = 30'sd55;
      21: r = 30'sd27;       22: r = 30'sd14;      23: r = 30'sd7;
      24: r = 30'sd3;        25: r = 30'sd2;       26: r = 30'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic                     zero;
    logic                     flip;
    logic signed [VecW-1:0]   x;
    logic signed [VecW-1:0]   y;
    logic signed [AngW-1:0]   z;
    logic signed [RotW-1:0]   u;
    logic signed [RotW-1:0]   v;
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] ey;
    logic        [OffW-1:0]   off;
  } cordic_t;
endpackage
`default_nettype wire

[design/shpo_stage.sv]
// One registered CORDIC vectoring micro-rotation, also rotating the offset vector.
`default_nettype none
module shpo_stage #(
  parameter int Shift = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire shpo_pkg::cordic_t data_i,
  output logic                   valid_o,
  output shpo_pkg::cordic_t      data_o
);
  shpo_pkg::cordic_t d;
  logic valid_q;
  shpo_pkg::cordic_t data_q;

  always_comb begin
    d = data_i;
    if (data_i.y >= 0) begin
      d.x = data_i.x + (data_i.y >>> Shift);
      d.y = data_i.y - (data_i.x >>> Shift);
      d.z = data_i.z + shpo_pkg::atan_udeg(Shift);
      d.u = data_i.u - (data_i.v >>> Shift);
      d.v = data_i.v + (data_i.u >>> Shift);
    end else begin
      d.x = data_i.x - (data_i.y >>> Shift);
      d.y = data_i.y + (data_i.x >>> Shift);
      d.z = data_i.z - shpo_pkg::atan_udeg(Shift);
      d.u = data_i.u + (data_i.v >>> Shift);
      d.v = data_i.v - (data_i.u >>> Shift);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= d;
  end

  assign valid_o = valid_q;
  assign data_o = data_q;
endmodule
`default_nettype wire

[design/segment_heading_pen_offset.sv]
// Top level: segment heading and rotation-centre stop point, fully pipelined.
// A segment is taken in every cycle (busy is always low) and its result shows
// on the result ports, marked by done_o, after the registered stages in turn:
// the entry stage forms the difference vector and the scaled offset (20x32
// multiply), a CORDIC stage does each micro-rotation, the rounding stage rounds
// the offset vector and folds the angle to magnitude plus one half, and the
// output stage subtracts and saturates the target while the heading is divided
// by 1000 through a reciprocal multiply. The receiver cannot stall; each result
// is valid for exactly one cycle. The marker offset is sampled when the segment
// enters, so the config channel is always ready and a transfer lands at once.
`default_nettype none
module segment_heading_pen_offset #(
  parameter int ANGLE_STAGES = 20
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic signed [23:0]  start_x_i,
  input  wire logic signed [23:0]  start_y_i,
  input  wire logic signed [23:0]  end_x_i,
  input  wire logic signed [23:0]  end_y_i,
  output logic                     done_o,
  output logic signed [18:0]       heading_millideg_o,
  output logic signed [23:0]       center_x_o,
  output logic signed [23:0]       center_y_o,
  output logic                     clipped_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [19:0]         cfg_data_i
);
  localparam int Stages = (ANGLE_STAGES > 32) ? 32 : ANGLE_STAGES;
  localparam int VW = shpo_pkg::VecW;
  localparam int RW = shpo_pkg::RotW;
  localparam int AW = shpo_pkg::AngW;
  localparam int CW = shpo_pkg::CoordW;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic [shpo_pkg::OffW-1:0] offset_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= 20'd45000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      offset_q <= cfg_data_i;
    end
  end

  // Entry stage: differences, half-plane fold, offset times 1/K.
  logic signed [shpo_pkg::DiffW-1:0] dx, dy;
  shpo_pkg::cordic_t ent_d, ent_q;
  logic ent_vq;
  always_comb begin
    dx = 25'(end_x_i) - 25'(start_x_i);
    dy = 25'(end_y_i) - 25'(start_y_i);
    ent_d.zero = (dx == '0) && (dy == '0);
    ent_d.flip = dx[shpo_pkg::DiffW-1];
    ent_d.x = ent_d.flip ? -(VW'(dx) <<< 30) : (VW'(dx) <<< 30);
    ent_d.y = ent_d.flip ? -(VW'(dy) <<< 30) : (VW'(dy) <<< 30);
    ent_d.z = !ent_d.flip ? '0 :
              (dy[shpo_pkg::DiffW-1] ? -shpo_pkg::HalfTurnUdeg : shpo_pkg::HalfTurnUdeg);
    ent_d.u = RW'($signed({1'b0, RW'(offset_q) * RW'(shpo_pkg::InvKQ32)}));
    ent_d.v = '0;
    ent_d.ex = end_x_i;
    ent_d.ey = end_y_i;
    ent_d.off = offset_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vq <= 1'b0;
    end else begin
      ent_vq <= start && !busy;
    end
  end
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  logic              vld [Stages+1];
  shpo_pkg::cordic_t pipe [Stages+1];
  assign vld[0] = ent_vq;
  assign pipe[0] = ent_q;

  for (genvar g = 0; g < Stages; g++) begin : g_stage
    shpo_stage #(.Shift(g)) u_stage (
      .clk_i(clk_i), .rst_ni(rst_ni),
      .valid_i(vld[g]), .data_i(pipe[g]),
      .valid_o(vld[g+1]), .data_o(pipe[g+1])
    );
  end

  // Rounding stage: offset vector to micrometres, angle to |z| + 500 and sign.
  shpo_pkg::cordic_t fin;
  logic signed [RW-1:0] ur, vr;
  logic signed [CW:0] ox_d, oy_d, ox_q, oy_q;
  logic signed [AW-1:0] za, zn;
  logic [AW-1:0] zr_d, zr_q;
  logic zneg_q, hsat_d, hsat_q;
  logic signed [CW-1:0] ex_q, ey_q;
  logic rnd_vq;
  always_comb begin
    fin = pipe[Stages];
    ur = (fin.u + (RW'(1) <<< 31)) >>> 32;
    vr = (fin.v + (RW'(1) <<< 31)) >>> 32;
    if (fin.zero) begin
      ox_d = (CW+1)'(fin.off);
      oy_d = '0;
      za = '0;
    end else begin
      ox_d = fin.flip ? -(CW+1)'(ur) : (CW+1)'(ur);
      oy_d = fin.flip ? -(CW+1)'(vr) : (CW+1)'(vr);
      za = fin.z;
    end
    zn = za[AW-1] ? -za : za;
    zr_d = zn + AW'(500);
    hsat_d = zr_d >= shpo_pkg::HeadSatUdeg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_vq <= 1'b0;
    end else begin
      rnd_vq <= vld[Stages];
    end
  end
  always_ff @(posedge clk_i) begin
    ox_q <= ox_d;
    oy_q <= oy_d;
    zr_q <= zr_d;
    zneg_q <= za[AW-1];
    hsat_q <= hsat_d;
    ex_q <= fin.ex;
    ey_q <= fin.ey;
  end

  // Output stage: subtract and saturate; heading = sign * floor((|z| + 500) / 1000).
  logic signed [CW+1:0] tx, ty;
  logic cx, cy;
  logic signed [CW-1:0] sx, sy;
  logic [58:0] hprod;
  logic [18:0] hmag;
  logic signed [18:0] head_d;
  always_comb begin
    tx = (CW+2)'(ex_q) - (CW+2)'(ox_q);
    ty = (CW+2)'(ey_q) - (CW+2)'(oy_q);
    cx = (tx > (CW+2)'(8388607)) || (tx < -(CW+2)'(8388608));
    cy = (ty > (CW+2)'(8388607)) || (ty < -(CW+2)'(8388608));
    sx = !cx ? CW'(tx) : (tx[CW+1] ? 24'sh800000 : 24'sh7fffff);
    sy = !cy ? CW'(ty) : (ty[CW+1] ? 24'sh800000 : 24'sh7fffff);
    hprod = 59'(zr_q) * 59'(shpo_pkg::Recip1000);
    hmag = hsat_q ? 19'd180000 : hprod[shpo_pkg::RecipShift +: 19];
    head_d = zneg_q ? -$signed(hmag) : $signed(hmag);
  end

  logic out_vq;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else begin
      out_vq <= rnd_vq;
    end
  end
  always_ff @(posedge clk_i) begin
    heading_millideg_o <= head_d;
    center_x_o <= sx;
    center_y_o <= sy;
    clipped_o <= cx || cy;
  end
  assign done_o = out_vq;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_vq |=> done_o) else $error("result lost in output stage");
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (heading_millideg_o <= 19'sd180000 && heading_millideg_o >= -19'sd180000))
    else $error("heading out of range");
  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> ent_vq) else $error("segment dropped at entry");
endmodule
`default_nettype wire

[verif/shpo_checker.sv]
// Checker: watches the segment and config channels, predicts heading and stop point, compares.
`timescale 1ns / 1ps
module shpo_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic signed [23:0] start_x_i,
  input  wire logic signed [23:0] start_y_i,
  input  wire logic signed [23:0] end_x_i,
  input  wire logic signed [23:0] end_y_i,
  input  wire logic               done_o,
  input  wire logic signed [18:0] heading_millideg_o,
  input  wire logic signed [23:0] center_x_o,
  input  wire logic signed [23:0] center_y_o,
  input  wire logic               clipped_o,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_o,
  input  wire logic [19:0]        cfg_data_i,
  output int                      fail_count,
  output int                      pending_count,
  output int                      result_count
);
  localparam int Stages = 20;

  typedef struct {
    logic signed [18:0] heading;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic               clip;
  } stop_point_t;

  stop_point_t expected_stops[$];
  logic [19:0] offset_reg;

  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -1 - ((-1 - v) >>> s);
  endfunction

  function automatic longint clamp_coord(longint v, ref logic clip);
    if (v > 64'sd8388607) begin
      clip = 1'b1;
      return 64'sd8388607;
    end
    if (v < -64'sd8388608) begin
      clip = 1'b1;
      return -64'sd8388608;
    end
    return v;
  endfunction

  function automatic stop_point_t predict_stop(longint sx, longint sy, longint ex, longint ey,
                                               longint off);
    stop_point_t r;
    longint dx, dy, x, y, z, u, v, xs, ys, us, vs, ox, oy, h;
    logic flip, clip;
    dx = ex - sx;
    dy = ey - sy;
    z = 0;
    clip = 1'b0;
    if (dx == 0 && dy == 0) begin
      ox = off;
      oy = 0;
    end else begin
      flip = dx < 0;
      if (flip) begin
        x = -dx * (64'sd1 << 30);
        y = -dy * (64'sd1 << 30);
        z = (dy >= 0) ? 64'sd180000000 : -64'sd180000000;
      end else begin
        x = dx * (64'sd1 << 30);
        y = dy * (64'sd1 << 30);
      end
      u = off * 64'sd2608131497;
      v = 0;
      for (int i = 0; i < Stages; i++) begin
        xs = floor_shift(x, i);
        ys = floor_shift(y, i);
        us = floor_shift(u, i);
        vs = floor_shift(v, i);
        if (y >= 0) begin
          x = x + ys; y = y - xs; z = z + shpo_pkg::atan_udeg(i);
          u = u - vs; v = v + us;
        end else begin
          x = x - ys; y = y + xs; z = z - shpo_pkg::atan_udeg(i);
          u = u + vs; v = v - us;
        end
      end
      ox = floor_shift(u + (64'sd1 << 31), 32);
      oy = floor_shift(v + (64'sd1 << 31), 32);
      if (flip) begin
        ox = -ox;
        oy = -oy;
      end
    end
    if (z >= 0) h = (z + 500) / 1000;
    else h = -((-z + 500) / 1000);
    if (h > 180000) h = 180000;
    if (h < -180000) h = -180000;
    r.heading = h[18:0];
    r.cx = 24'(clamp_coord(ex - ox, clip));
    r.cy = 24'(clamp_coord(ey - oy, clip));
    r.clip = clip;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stop_point_t e;
    if (!rst_ni) begin
      offset_reg <= 20'd45000;
      fail_count <= 0;
      result_count <= 0;
      expected_stops.delete();
    end else begin
      // segment transfer uses the offset in force before a same-edge config write
      if (start && !busy)
        expected_stops.push_back(predict_stop(start_x_i, start_y_i, end_x_i, end_y_i,
                                              offset_reg));
      if (cfg_valid_i && cfg_ready_o) offset_reg <= cfg_data_i;
      if (done_o) begin
        result_count <= result_count + 1;
        if (expected_stops.size() == 0) begin
          $error("unexpected result");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_stops.pop_front();
          if (heading_millideg_o !== e.heading || center_x_o !== e.cx ||
              center_y_o !== e.cy || clipped_o !== e.clip) begin
            if (heading_millideg_o !== e.heading)
              $error("heading_millideg exp %0d got %0d", e.heading, heading_millideg_o);
            if (center_x_o !== e.cx)
              $error("center_x exp %0d got %0d", e.cx, center_x_o);
            if (center_y_o !== e.cy)
              $error("center_y exp %0d got %0d", e.cy, center_y_o);
            if (clipped_o !== e.clip)
              $error("clipped exp %0b got %0b", e.clip, clipped_o);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending_count = expected_stops.size();
endmodule

[verif/tb_top.sv]
// Testbench top: clock, reset, segment and offset stimulus, verdict.
`timescale 1ns / 1ps
module tb_top;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [23:0] start_x_i = '0, start_y_i = '0, end_x_i = '0, end_y_i = '0;
  logic done_o, clipped_o, cfg_ready_o;
  logic signed [18:0] heading_millideg_o;
  logic signed [23:0] center_x_o, center_y_o;
  logic cfg_valid_i = 1'b0;
  logic [19:0] cfg_data_i = '0;
  int fail_count, pending_count, result_count;
  int idle_cycles;        // cycles since the last transfer of any kind
  int segments_sent;
  localparam int IdleLimit = 2000;
  localparam int DrainCycles = 40;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  segment_heading_pen_offset #(.ANGLE_STAGES(20)) u_dut (.*);

  shpo_checker u_chk (.*);

  // watchdog: no transfer for too long means a hang
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // pick a coordinate: extremes, near-zero, or full range
  function automatic int pick_coord();
    case ($urandom_range(0, 5))
      0: return 8388607;
      1: return -8388608;
      2: return int'($urandom_range(0, 200)) - 100;
      default: return int'($signed(24'($urandom)));
    endcase
  endfunction

  // one segment transfer, after a random gap when pause is set; this task drops start only during such a gap
  task automatic send_segment(int sx, int sy, int ex, int ey, bit pause);
    int gap;
    gap = pause ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    start_x_i <= 24'(sx); start_y_i <= 24'(sy); end_x_i <= 24'(ex); end_y_i <= 24'(ey);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    segments_sent++;
    @(negedge clk_i);
  endtask

  // config written only with the pipeline drained
  task automatic write_offset(logic [19:0] val);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [19:0] offsets[5];
    bit pause;
    segments_sent = 0;
    idle_cycles = 0;
    offsets = '{20'd0, 20'hfffff, 20'd1, 20'd45000, 20'd0};
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: zero length, axes, diagonals, left half plane on both sides, extremes
    send_segment(0, 0, 0, 0, 1'b0);
    send_segment(8388607, -8388608, 8388607, -8388608, 1'b0);
    send_segment(0, 0, 1000, 0, 1'b1);
    send_segment(0, 0, -1000, 0, 1'b1);
    send_segment(0, 0, -1000, 1, 1'b0);
    send_segment(0, 0, -1000, -1, 1'b0);
    send_segment(0, 0, 0, 1000, 1'b0);
    send_segment(0, 0, 0, -1000, 1'b1);
    send_segment(0, 0, 500, 500, 1'b0);
    send_segment(0, 0, -500, -500, 1'b0);
    send_segment(-8388608, -8388608, 8388607, 8388607, 1'b0);
    send_segment(8388607, 8388607, -8388608, -8388608, 1'b0);
    send_segment(8388607, 0, -8388608, 0, 1'b1);
    send_segment(0, 0, -8388608, -8388608, 1'b0);   // end at the low corner of the range
    send_segment(-8388608, 0, 8388607, 8388607, 1'b0);
    write_offset(20'hfffff);
    send_segment(0, 0, 8388592, 0, 1'b0);
    send_segment(0, 0, -8388592, 10, 1'b0);
    send_segment(0, 0, -3, 8388607, 1'b0);

    // random phases across several offsets, extremes included
    for (int p = 0; p < 6; p++) begin
      write_offset(p < 5 ? offsets[p] : 20'($urandom));
      for (int k = 0; k < 265; k++) begin
        pause = $urandom_range(0, 3) != 0 || p == 2;
        if (p == 2) pause = 0;   // back-to-back stretch
        send_segment(pick_coord(), pick_coord(), pick_coord(), pick_coord(), pause);
      end
    end
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d segments over several marker offsets, %0d results checked.",
             segments_sent, result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
